// ===== design/stb_pkg.sv =====
// ----------------------------------------------------------------------------
// stb_pkg: shared types, constants and table function for the tone burst
// Register indexes, reset values, sequencer states and the quarter-wave
// sine entry function used to build the sine ROM.
// ----------------------------------------------------------------------------
package stb_pkg;

   localparam int SINE_TABLE_DEPTH_DEFAULT = 256;
   localparam int LENGTH_BITS_DEFAULT      = 24;

   localparam int GAIN_BITS     = 15;
   localparam int RAMP_BITS     = 16;
   localparam int PHASE_BITS    = 32;
   localparam int DURATION_BITS = 24;
   localparam int SAMPLE_BITS   = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 15'd16384;
   localparam logic [RAMP_BITS-1:0]  RAMP_RESET  = 16'd240;
   localparam logic [PHASE_BITS-1:0] STEP_RESET  = 32'd78741067;
   localparam logic [GAIN_BITS-1:0]  FULL_SCALE  = 15'd32767;
   localparam logic [63:0]           HALF_PI_Q30 = 64'd1686629713;

   // Divide steps: quotient of the ramp scaling always fits in 15 bits
   localparam int DIV_STEPS    = 15;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_BITS-1:0] CSR_VOLUME_GAIN  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RAMP_SAMPLES = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PHASE_STEP   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_GAIN,
      ST_MUL_ENV,
      ST_DIV,
      ST_OUT
   } state_type;

   // Q30 Taylor series of sin(angle), scaled to 32767 and rounded
   function automatic logic [14:0] sine_from_angle(input logic [63:0] angle);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] r;
      longint      sum;
      x2   = (angle * angle) >> 30;
      term = angle;
      sum  = longint'(angle);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      r = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[14:0];
   endfunction

endpackage

// ===== design/stb_sine_rom.sv =====
// ----------------------------------------------------------------------------
// stb_sine_rom: quarter-wave sine table, Q0.15 magnitudes
// Entry k holds sin(pi/2 * k / DEPTH) * 32767; read data is registered.
// ----------------------------------------------------------------------------
module stb_sine_rom
   import stb_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] rd_addr,
   output logic [GAIN_BITS-1:0]                rd_data
);

   logic [GAIN_BITS-1:0] rom_table [SINE_TABLE_DEPTH];
   logic [GAIN_BITS-1:0] data_ff;

   for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_entry
      localparam logic [63:0] ANGLE = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      assign rom_table[k] = sine_from_angle(ANGLE);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= rom_table[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

// ===== design/sine_tone_burst_with_ramps.sv =====
// ----------------------------------------------------------------------------
// sine_tone_burst_with_ramps: sine tone bursts with linear fade in and out
// Phase accumulator, quarter-wave ROM and a shared multiply/divide sequencer
// produce one signed 16-bit PCM word per tick of an active tone.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  input words. kind 0 starts a tone (length, audible flag) and clears
//          phase and sample index; it gives no response. kind 1 is a tick: one
//          rsp word per tick while a tone is active, nothing while idle.
//   rsp_*  PCM sample, its low and high bytes, and a flag on the tone's last
//          sample.
//   csr_*  register writes (0 gain, 1 ramp length, 2 phase step), always
//          ready; write only while the block is idle.
// Timing: outside the ramps a tick passes MUL_GAIN then OUT; inside them
//   MUL_ENV and DIV come between: one 30x16 multiplier is used twice
//   (gain times sine, then times the envelope count) and the envelope
//   division runs one quotient bit per cycle for all 15 quotient bits.
//   req_ready is high only while the sequencer is idle.
// Stall: the response sits in an output register; the next word is accepted
//   while it waits, and the sequencer holds its finished sample until the
//   register frees up.
// Reset: synchronous; registers go to their defaults and no tone is active.
// ----------------------------------------------------------------------------
module sine_tone_burst_with_ramps
   import stb_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEFAULT,
   parameter int LENGTH_BITS      = LENGTH_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic [DURATION_BITS-1:0] req_duration_samples,
   input  logic                     req_audible,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_audio_sample,
   output logic [7:0]               rsp_low_byte,
   output logic [7:0]               rsp_high_byte,
   output logic                     rsp_last_sample,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int AW       = $clog2(SINE_TABLE_DEPTH);
   localparam int MAG_BITS = 2 * GAIN_BITS;
   localparam int PROD_BITS = MAG_BITS + RAMP_BITS;

   state_type state_ff, state_in;

   logic [GAIN_BITS-1:0]   gain_ff;
   logic [RAMP_BITS-1:0]   ramp_ff;
   logic [PHASE_BITS-1:0]  step_ff;

   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] index_ff, index_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic                   active_ff, active_in;
   logic                   audible_ff, audible_in;

   // per-sample working registers
   logic                   neg_ff, neg_in;
   logic                   full_ff, full_in;
   logic                   use_ramp_ff, use_ramp_in;
   logic                   last_ff, last_in;
   logic                   snd_ff, snd_in;
   logic [RAMP_BITS-1:0]   env_ff, env_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [RAMP_BITS-1:0]   rem_ff, rem_in;
   logic [GAIN_BITS-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;

   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_pcm_ff, out_pcm_in;
   logic                   out_last_ff, out_last_in;

   logic                   req_fire;
   logic                   tick_fire;
   logic [1:0]             quad;
   logic [AW-1:0]          point_k;
   logic [AW-1:0]          rom_addr;
   logic [GAIN_BITS-1:0]   rom_data;
   logic [GAIN_BITS-1:0]   sine_mag;
   logic [LENGTH_BITS-1:0] remain;
   logic [LENGTH_BITS-1:0] index_next;
   logic [LENGTH_BITS-1:0] ramp_ext;
   logic [MAG_BITS-1:0]    mul_a;
   logic [RAMP_BITS-1:0]   mul_b;
   logic [PROD_BITS-1:0]   mul_out;
   logic [RAMP_BITS:0]     rem_shift;
   logic                   div_fits;
   logic [SAMPLE_BITS-1:0] mag_word;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign tick_fire = req_fire && req_kind && active_ff;
   assign csr_ready = 1'b1;

   // phase to table address: quadrant from the top bits, mirror on odd ones
   assign quad     = phase_ff[PHASE_BITS-1 -: 2];
   assign point_k  = phase_ff[PHASE_BITS-3 -: AW];
   assign rom_addr = quad[0] ? (AW'(0) - point_k) : point_k;

   stb_sine_rom #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_rom (
      .clock   (clock),
      .rd_en   (tick_fire),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   assign sine_mag   = full_ff ? FULL_SCALE : rom_data;
   assign remain     = length_ff - index_ff;
   assign index_next = index_ff + LENGTH_BITS'(1);
   assign ramp_ext   = LENGTH_BITS'(ramp_ff);

   // shared multiplier: gain x sine, then magnitude x envelope count
   assign mul_a   = (state_ff == ST_MUL_GAIN) ? MAG_BITS'(gain_ff) : prod_ff[MAG_BITS-1:0];
   assign mul_b   = (state_ff == ST_MUL_GAIN) ? RAMP_BITS'(sine_mag) : env_ff;
   assign mul_out = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

   // restoring divide step by the ramp length
   assign rem_shift = {rem_ff, quo_ff[GAIN_BITS-1]};
   assign div_fits  = rem_shift >= {1'b0, ramp_ff};
   assign mag_word  = {1'b0, quo_ff};

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      index_in     = index_ff;
      length_in    = length_ff;
      active_in    = active_ff;
      audible_in   = audible_ff;
      neg_in       = neg_ff;
      full_in      = full_ff;
      use_ramp_in  = use_ramp_ff;
      last_in      = last_ff;
      snd_in       = snd_ff;
      env_in       = env_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_pcm_in   = out_pcm_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && !req_kind) begin
               length_in  = LENGTH_BITS'(req_duration_samples);
               audible_in = req_audible;
               phase_in   = '0;
               index_in   = '0;
               active_in  = (LENGTH_BITS'(req_duration_samples) != '0);
            end else if (tick_fire) begin
               neg_in  = quad[1];
               full_in = quad[0] && (point_k == '0);
               snd_in  = audible_ff;
               last_in = (index_next == length_ff);
               if (ramp_ff != '0 && index_ff < ramp_ext) begin
                  use_ramp_in = 1'b1;
                  env_in      = RAMP_BITS'(index_ff);
               end else if (ramp_ff != '0 && remain < ramp_ext) begin
                  use_ramp_in = 1'b1;
                  env_in      = RAMP_BITS'(remain);
               end else begin
                  use_ramp_in = 1'b0;
                  env_in      = '0;
               end
               phase_in = phase_ff + step_ff;
               index_in = index_next;
               if (index_next == length_ff) begin
                  active_in = 1'b0;
               end
               state_in = ST_MUL_GAIN;
            end
         end
         ST_MUL_GAIN: begin
            prod_in = mul_out;
            quo_in  = mul_out[MAG_BITS-1:GAIN_BITS];
            state_in = use_ramp_ff ? ST_MUL_ENV : ST_OUT;
         end
         ST_MUL_ENV: begin
            // quotient of (mag*n >> 15) / R; high part already below R
            rem_in   = mul_out[PROD_BITS-1 -: RAMP_BITS];
            quo_in   = mul_out[MAG_BITS-1:GAIN_BITS];
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = div_fits ? RAMP_BITS'(rem_shift - {1'b0, ramp_ff})
                              : RAMP_BITS'(rem_shift);
            quo_in = {quo_ff[GAIN_BITS-2:0], div_fits};
            cnt_in = cnt_ff + DIV_CNT_BITS'(1);
            if (cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_last_in  = last_ff;
               if (!snd_ff) begin
                  out_pcm_in = '0;
               end else if (neg_ff) begin
                  out_pcm_in = SAMPLE_BITS'(0) - mag_word;
               end else begin
                  out_pcm_in = mag_word;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         index_ff     <= '0;
         length_ff    <= '0;
         active_ff    <= 1'b0;
         audible_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         length_ff    <= length_in;
         active_ff    <= active_in;
         audible_ff   <= audible_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      full_ff     <= full_in;
      use_ramp_ff <= use_ramp_in;
      last_ff     <= last_in;
      snd_ff      <= snd_in;
      env_ff      <= env_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      out_pcm_ff  <= out_pcm_in;
      out_last_ff <= out_last_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         ramp_ff <= RAMP_RESET;
         step_ff <= STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VOLUME_GAIN:  gain_ff <= csr_data[GAIN_BITS-1:0];
            CSR_RAMP_SAMPLES: ramp_ff <= csr_data[RAMP_BITS-1:0];
            CSR_PHASE_STEP:   step_ff <= csr_data[PHASE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_audio_sample = out_pcm_ff;
   assign rsp_low_byte     = out_pcm_ff[7:0];
   assign rsp_high_byte    = out_pcm_ff[15:8];
   assign rsp_last_sample  = out_last_ff;

endmodule
